// File: rtl/pfsws_pkg.sv
// Package for the per-flow sliding window sum block.
// Holds request and status codes, FSM states, result record and default sizes.
// No dependencies.
`default_nettype none

package pfsws_pkg;

	localparam int NUM_FLOWS_DEF  = 1024;
	localparam int MAX_WINDOW_DEF = 16;

	// valid bitmap word layout
	localparam int BM_WORD_W = 32;
	localparam int BM_BIT_W  = 5;

	localparam int KEY_W    = 10;
	localparam int VALUE_W  = 32;
	localparam int WSIZE_W  = 16;
	localparam int SIZE_W   = 5;
	localparam int MODE_W   = 3;
	localparam int STATUS_W = 2;

	localparam logic [MODE_W-1:0] MODE_CREATE = 3'd0;
	localparam logic [MODE_W-1:0] MODE_ADD    = 3'd1;
	localparam logic [MODE_W-1:0] MODE_GET    = 3'd2;
	localparam logic [MODE_W-1:0] MODE_REMOVE = 3'd3;

	localparam logic [STATUS_W-1:0] STAT_OK      = 2'd0;
	localparam logic [STATUS_W-1:0] STAT_NO_RES  = 2'd1;
	localparam logic [STATUS_W-1:0] STAT_BAD_KEY = 2'd2;
	localparam logic [STATUS_W-1:0] STAT_BAD_OP  = 2'd3;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_META,
		S_SCAN,
		S_ADD,
		S_OUT
	} state_t;

	typedef struct packed {
		logic [SIZE_W-1:0]   size_out;
		logic [VALUE_W-1:0]  sum;
		logic [KEY_W-1:0]    flow_key;
		logic [STATUS_W-1:0] status;
	} result_t;

endpackage

`default_nettype wire

// File: rtl/per_flow_sliding_window_sum.sv
// Per-flow sliding window sum: flow table, per-flow windows and valid bitmap.
// One request in flight; accept, metadata read, execute, result register.
// Create scans the valid bitmap memory one word per cycle for the lowest free flow, up to
// ceil(NUM_FLOWS/32) words. Reset: arst_n clears control; then a clearing pass over all
// bitmap words zeroes the valid bitmap, s_tready stays low meanwhile. Depends on pfsws_pkg.
`default_nettype none

module per_flow_sliding_window_sum #(
	parameter int NUM_FLOWS  = pfsws_pkg::NUM_FLOWS_DEF,
	parameter int MAX_WINDOW = pfsws_pkg::MAX_WINDOW_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [63:0] s_tdata,   // key[9:0], value[41:10], win_len[57:42], zero
	input  wire logic [2:0]  s_tuser,   // mode[2:0]
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [47:0]      m_tdata,   // flow_key[9:0], sum[41:10], size_out[46:42], zero
	output logic [1:0]       m_tuser    // status[1:0]
);

	localparam int BMW      = pfsws_pkg::BM_WORD_W;
	localparam int FLOW_W   = $clog2(NUM_FLOWS);
	localparam int LEN_W    = $clog2(MAX_WINDOW + 1);
	localparam int POS_W    = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
	localparam int BM_WORDS = (NUM_FLOWS + BMW - 1) / BMW;
	localparam int BM_AW    = (BM_WORDS > 1) ? $clog2(BM_WORDS) : 1;
	localparam int WIN_AW   = FLOW_W + POS_W;
	localparam int WIN_DEPTH = NUM_FLOWS * (2 ** POS_W);
	localparam logic [BM_AW-1:0] BM_LAST = BM_AW'(BM_WORDS - 1);

	typedef struct packed {
		logic [31:0]      total;
		logic             wrapped;
		logic [POS_W-1:0] pos;
		logic [LEN_W-1:0] len;
	} meta_t;

	pfsws_pkg::state_t state_q, state_d;

	logic [2:0]  req_mode_q;
	logic [9:0]  req_key_q;
	logic [31:0] req_value_q;
	logic [15:0] req_size_q;

	logic [BM_AW-1:0] clr_idx_q;
	logic [BM_AW-1:0] scan_idx_q, scan_idx_d;

	logic [BMW-1:0] bm_mem [0:BM_WORDS-1];
	logic [BMW-1:0] bm_rd_q, bm_wdata;
	logic [BM_AW-1:0] bm_raddr, bm_waddr;
	logic bm_we;

	meta_t meta_mem [0:NUM_FLOWS-1];
	meta_t meta_rd_q, meta_wdata;
	logic [FLOW_W-1:0] meta_raddr, meta_waddr;
	logic meta_we;

	logic [31:0] win_mem [0:WIN_DEPTH-1];
	logic [31:0] win_rd_q, win_wdata;
	logic [WIN_AW-1:0] win_raddr, win_waddr;
	logic win_we;

	pfsws_pkg::result_t res_q, res_d, out_q;
	logic res_ld, out_ld, out_valid_q;

	logic s_accept;
	logic [31:0] in_key_ext, in_bm_tmp, req_key_ext, req_bm_tmp;
	logic [FLOW_W-1:0] in_flow, req_flow, alloc_flow;
	logic [BM_AW-1:0] in_bm_addr, req_bm_addr;
	logic [4:0] req_bit;
	logic key_ok, in_use, size_ok;

	logic [31:0] scan_base, alloc32;
	logic [BMW-1:0] in_range, avail, low1;
	logic [4:0] free_bit;
	logic found;

	logic [LEN_W-1:0] len_fix;
	logic [POS_W-1:0] pos_fix, pos_new;
	logic [31:0] pos_inc32, old_val, len32;
	logic wrap_new;

	assign s_tready = (state_q == pfsws_pkg::S_IDLE);
	assign s_accept = s_tvalid && s_tready;
	assign m_tvalid = out_valid_q;
	assign m_tdata  = {1'b0, out_q.size_out, out_q.sum, out_q.flow_key};
	assign m_tuser  = out_q.status;

	// address decode, from the port while idle and from the request register after
	assign in_key_ext  = {22'd0, s_tdata[9:0]};
	assign in_flow     = in_key_ext[FLOW_W-1:0];
	assign in_bm_tmp   = in_key_ext >> pfsws_pkg::BM_BIT_W;
	assign in_bm_addr  = in_bm_tmp[BM_AW-1:0];
	assign req_key_ext = {22'd0, req_key_q};
	assign req_flow    = req_key_ext[FLOW_W-1:0];
	assign req_bm_tmp  = req_key_ext >> pfsws_pkg::BM_BIT_W;
	assign req_bm_addr = req_bm_tmp[BM_AW-1:0];
	assign req_bit     = req_key_ext[4:0];
	assign key_ok      = req_key_ext < 32'(NUM_FLOWS);
	assign in_use      = bm_rd_q[req_bit];
	assign size_ok     = (req_size_q != 16'd0) && (32'(req_size_q) <= 32'(MAX_WINDOW));

	// lowest free flow in the current bitmap word
	assign scan_base = 32'(scan_idx_q) << pfsws_pkg::BM_BIT_W;
	always_comb begin
		for (int b = 0; b < BMW; b++) begin
			in_range[b] = (scan_base + 32'(b)) < 32'(NUM_FLOWS);
		end
	end
	assign avail = ~bm_rd_q & in_range;
	assign low1  = avail & (~avail + 32'd1);
	assign found = |avail;
	always_comb begin
		free_bit = 5'd0;
		for (int b = 0; b < BMW; b++) begin
			free_bit = free_bit | (low1[b] ? 5'(b) : 5'd0);
		end
	end
	assign alloc32    = scan_base | 32'(free_bit);
	assign alloc_flow = alloc32[FLOW_W-1:0];

	// window slot arithmetic for add
	always_comb begin
		len_fix = meta_rd_q.len;
		if (meta_rd_q.len == '0 || 32'(meta_rd_q.len) > 32'(MAX_WINDOW)) begin
			len_fix = LEN_W'(1);
		end
		pos_fix = meta_rd_q.pos;
		if (32'(meta_rd_q.pos) >= 32'(len_fix)) begin
			pos_fix = '0;
		end
		pos_inc32 = 32'(pos_fix) + 32'd1;
		wrap_new  = meta_rd_q.wrapped;
		pos_new   = pos_inc32[POS_W-1:0];
		if (pos_inc32 >= 32'(len_fix)) begin
			pos_new  = '0;
			wrap_new = 1'b1;
		end
	end
	assign old_val = meta_rd_q.wrapped ? win_rd_q : 32'd0;
	assign len32   = 32'(meta_rd_q.len);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pfsws_pkg::S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		bm_raddr   = req_bm_addr;
		bm_we      = 1'b0;
		bm_waddr   = req_bm_addr;
		bm_wdata   = bm_rd_q;
		meta_raddr = req_flow;
		meta_we    = 1'b0;
		meta_waddr = req_flow;
		meta_wdata = meta_rd_q;
		win_raddr  = {req_flow, pos_fix};
		win_we     = 1'b0;
		win_waddr  = {req_flow, pos_fix};
		win_wdata  = req_value_q;
		scan_idx_d = scan_idx_q;
		res_ld     = 1'b0;
		res_d      = '{size_out: '0, sum: '0, flow_key: req_key_q,
			status: pfsws_pkg::STAT_OK};
		out_ld     = 1'b0;
		unique case (state_q)
			pfsws_pkg::S_CLEAR: begin
				bm_we    = 1'b1;
				bm_waddr = clr_idx_q;
				bm_wdata = '0;
				if (clr_idx_q == BM_LAST) begin
					state_d = pfsws_pkg::S_IDLE;
				end
			end
			pfsws_pkg::S_IDLE: begin
				bm_raddr   = in_bm_addr;
				meta_raddr = in_flow;
				if (s_accept) begin
					state_d = pfsws_pkg::S_META;
				end
			end
			pfsws_pkg::S_META: begin
				priority if (req_mode_q == pfsws_pkg::MODE_CREATE) begin
					if (size_ok) begin
						bm_raddr   = '0;
						scan_idx_d = '0;
						state_d    = pfsws_pkg::S_SCAN;
					end else begin
						res_ld         = 1'b1;
						res_d.status   = pfsws_pkg::STAT_NO_RES;
						res_d.flow_key = '0;
						state_d        = pfsws_pkg::S_OUT;
					end
				end else if (req_mode_q > pfsws_pkg::MODE_REMOVE) begin
					res_ld       = 1'b1;
					res_d.status = pfsws_pkg::STAT_BAD_OP;
					state_d      = pfsws_pkg::S_OUT;
				end else if (!key_ok || !in_use) begin
					res_ld       = 1'b1;
					res_d.status = pfsws_pkg::STAT_BAD_KEY;
					state_d      = pfsws_pkg::S_OUT;
				end else if (req_mode_q == pfsws_pkg::MODE_ADD) begin
					state_d = pfsws_pkg::S_ADD;
				end else if (req_mode_q == pfsws_pkg::MODE_GET) begin
					res_ld         = 1'b1;
					res_d.sum      = meta_rd_q.total;
					res_d.size_out = len32[4:0];
					state_d        = pfsws_pkg::S_OUT;
				end else begin
					bm_we    = 1'b1;
					bm_wdata = bm_rd_q & ~(32'd1 << req_bit);
					res_ld   = 1'b1;
					state_d  = pfsws_pkg::S_OUT;
				end
			end
			pfsws_pkg::S_SCAN: begin
				bm_raddr = scan_idx_q + BM_AW'(1);
				if (found) begin
					bm_we      = 1'b1;
					bm_waddr   = scan_idx_q;
					bm_wdata   = bm_rd_q | low1;
					meta_we    = 1'b1;
					meta_waddr = alloc_flow;
					meta_wdata = '{total: '0, wrapped: 1'b0, pos: '0,
						len: req_size_q[LEN_W-1:0]};
					res_ld         = 1'b1;
					res_d.flow_key = alloc32[9:0];
					state_d        = pfsws_pkg::S_OUT;
				end else if (scan_idx_q == BM_LAST) begin
					res_ld         = 1'b1;
					res_d.status   = pfsws_pkg::STAT_NO_RES;
					res_d.flow_key = '0;
					state_d        = pfsws_pkg::S_OUT;
				end else begin
					scan_idx_d = scan_idx_q + BM_AW'(1);
				end
			end
			pfsws_pkg::S_ADD: begin
				win_we     = 1'b1;
				meta_we    = 1'b1;
				meta_wdata = '{total: meta_rd_q.total - old_val + req_value_q,
					wrapped: wrap_new, pos: pos_new, len: meta_rd_q.len};
				res_ld     = 1'b1;
				state_d    = pfsws_pkg::S_OUT;
			end
			pfsws_pkg::S_OUT: begin
				if (!out_valid_q || m_tready) begin
					out_ld  = 1'b1;
					state_d = pfsws_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = pfsws_pkg::S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_idx_q   <= '0;
			scan_idx_q  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == pfsws_pkg::S_CLEAR) begin
				clr_idx_q <= clr_idx_q + BM_AW'(1);
			end
			scan_idx_q <= scan_idx_d;
			if (out_ld) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_accept) begin
			req_mode_q  <= s_tuser;
			req_key_q   <= s_tdata[9:0];
			req_value_q <= s_tdata[41:10];
			req_size_q  <= s_tdata[57:42];
		end
		if (res_ld) begin
			res_q <= res_d;
		end
		if (out_ld) begin
			out_q <= res_q;
		end
	end

	always_ff @(posedge clk) begin
		if (bm_we) begin
			bm_mem[bm_waddr] <= bm_wdata;
		end
		bm_rd_q <= bm_mem[bm_raddr];
	end

	always_ff @(posedge clk) begin
		if (meta_we) begin
			meta_mem[meta_waddr] <= meta_wdata;
		end
		meta_rd_q <= meta_mem[meta_raddr];
	end

	always_ff @(posedge clk) begin
		if (win_we) begin
			win_mem[win_waddr] <= win_wdata;
		end
		win_rd_q <= win_mem[win_raddr];
	end

`ifndef SYNTHESIS
	a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		s_accept |=> state_q != pfsws_pkg::S_IDLE)
		else $error("request accepted but sequencer stayed idle");

	a_result_from_out: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(state_q == pfsws_pkg::S_OUT))
		else $error("result presented outside result state");

	a_no_res_fields: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == pfsws_pkg::STAT_NO_RES |->
		m_tdata[9:0] == 10'd0 && m_tdata[46:10] == 37'd0)
		else $error("failed create carries nonzero fields");

	a_size_only_ok: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[46:42] != 5'd0 |-> m_tuser == pfsws_pkg::STAT_OK)
		else $error("window length reported on a failed request");
`endif

endmodule

`default_nettype wire

// File: test/flow_sum_checker.sv
// Checker for the per-flow sliding window sum: watches both stream channels,
// predicts every reply from its own flow table and compares field by field.
// Depends on pfsws_pkg.
`default_nettype none

module flow_sum_checker (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	input  wire logic        s_tready,
	input  wire logic [63:0] s_tdata,   // key[9:0], value[41:10], win_len[57:42], zero
	input  wire logic [2:0]  s_tuser,   // mode[2:0]
	input  wire logic        m_tvalid,
	input  wire logic        m_tready,
	input  wire logic [47:0] m_tdata,   // flow_key[9:0], sum[41:10], size_out[46:42], zero
	input  wire logic [1:0]  m_tuser,   // status[1:0]
	output int               mismatches,
	output int               outstanding
);

	localparam int FLOWS = pfsws_pkg::NUM_FLOWS_DEF;
	localparam int WIN   = pfsws_pkg::MAX_WINDOW_DEF;

	bit                            flow_live    [FLOWS];
	logic [pfsws_pkg::SIZE_W-1:0]  flow_len     [FLOWS];
	int                            flow_pos     [FLOWS];
	bit                            flow_full    [FLOWS];
	logic [pfsws_pkg::VALUE_W-1:0] flow_sum     [FLOWS];
	logic [pfsws_pkg::VALUE_W-1:0] flow_samples [FLOWS][WIN];

	pfsws_pkg::result_t predicted_replies[$];
	int                 reply_count;

	function automatic pfsws_pkg::result_t apply_flow_request(
			logic [pfsws_pkg::MODE_W-1:0] mode, logic [pfsws_pkg::KEY_W-1:0] key,
			logic [pfsws_pkg::VALUE_W-1:0] value, logic [pfsws_pkg::WSIZE_W-1:0] wsize);
		pfsws_pkg::result_t            r;
		int                            f;
		int                            p;
		logic [pfsws_pkg::VALUE_W-1:0] old;
		r = '0;
		if (mode == pfsws_pkg::MODE_CREATE) begin
			r.status = pfsws_pkg::STAT_NO_RES;
			if (wsize == 0 || wsize > WIN)
				return r;
			for (f = 0; f < FLOWS; f++)
				if (!flow_live[f])
					break;
			if (f >= FLOWS)
				return r;
			flow_live[f] = 1'b1;
			flow_len[f]  = wsize[pfsws_pkg::SIZE_W-1:0];
			flow_pos[f]  = 0;
			flow_full[f] = 1'b0;
			flow_sum[f]  = '0;
			r.status     = pfsws_pkg::STAT_OK;
			r.flow_key   = f[pfsws_pkg::KEY_W-1:0];
			return r;
		end
		r.flow_key = key;
		if (mode > pfsws_pkg::MODE_REMOVE) begin
			r.status = pfsws_pkg::STAT_BAD_OP;
			return r;
		end
		if (!flow_live[key]) begin
			r.status = pfsws_pkg::STAT_BAD_KEY;
			return r;
		end
		r.status = pfsws_pkg::STAT_OK;
		case (mode)
			pfsws_pkg::MODE_ADD: begin
				p = flow_pos[key];
				// slots not yet written count as zero until the window first wraps
				old = flow_full[key] ? flow_samples[key][p] : '0;
				flow_sum[key] = flow_sum[key] - old + value;
				flow_samples[key][p] = value;
				p++;
				if (p >= flow_len[key]) begin
					p = 0;
					flow_full[key] = 1'b1;
				end
				flow_pos[key] = p;
			end
			pfsws_pkg::MODE_GET: begin
				r.sum      = flow_sum[key];
				r.size_out = flow_len[key];
			end
			default: flow_live[key] = 1'b0;
		endcase
		return r;
	endfunction

	task automatic report_mismatch(string what, longint got, longint want);
		$display("reply %0d: %s got 0x%0h, expected 0x%0h", reply_count, what, got, want);
		mismatches++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		pfsws_pkg::result_t got;
		pfsws_pkg::result_t want;
		if (!arst_n) begin
			foreach (flow_live[i])
				flow_live[i] = 1'b0;
			predicted_replies.delete();
			mismatches  = 0;
			outstanding = 0;
			reply_count = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				got.status   = m_tuser;
				got.flow_key = m_tdata[9:0];
				got.sum      = m_tdata[41:10];
				got.size_out = m_tdata[46:42];
				if (predicted_replies.size() == 0) begin
					report_mismatch("transaction with no request pending, status",
						got.status, 0);
				end else begin
					want = predicted_replies.pop_front();
					if (got.status != want.status)
						report_mismatch("status", got.status, want.status);
					if (got.flow_key != want.flow_key)
						report_mismatch("flow_key", got.flow_key, want.flow_key);
					if (got.sum != want.sum)
						report_mismatch("sum", got.sum, want.sum);
					if (got.size_out != want.size_out)
						report_mismatch("size_out", got.size_out, want.size_out);
				end
				reply_count++;
			end
			if (s_tvalid && s_tready)
				predicted_replies.push_back(apply_flow_request(s_tuser, s_tdata[9:0],
					s_tdata[41:10], s_tdata[57:42]));
			outstanding = predicted_replies.size();
		end
	end

endmodule

`default_nettype wire

// File: test/per_flow_sliding_window_sum_tb.sv
// Testbench top for the per-flow sliding window sum: drives create, add, get,
// remove and unknown requests in bursts, stalls the reply side, gives the verdict.
// Depends on pfsws_pkg, per_flow_sliding_window_sum and flow_sum_checker.
`default_nettype none

module per_flow_sliding_window_sum_tb;

	localparam int FLOWS = pfsws_pkg::NUM_FLOWS_DEF;
	localparam int WIN   = pfsws_pkg::MAX_WINDOW_DEF;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [63:0] s_tdata;
	logic [2:0]  s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [47:0] m_tdata;
	logic [1:0]  m_tuser;
	int          mismatches;
	int          outstanding;

	// stimulus-side view of which flows are allocated, to aim at live keys
	bit flow_taken[FLOWS];
	int live_keys[$];
	int burst_left;
	int sent;

	per_flow_sliding_window_sum dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	flow_sum_checker sum_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.s_tuser     (s_tuser),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.m_tuser     (m_tuser),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#6000000;
		$display("per_flow_sliding_window_sum: mismatch");
		$finish;
	end

	// reply side: random stall styles, one long hold-off so the block backs up
	initial begin
		int cyc;
		int run_left;
		int style;
		cyc      = 0;
		run_left = 0;
		style    = 0;
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			cyc++;
			if (cyc >= 2000 && cyc < 2400) begin
				m_tready <= 1'b0;
			end else begin
				if (run_left == 0) begin
					style    = $urandom_range(0, 2);
					run_left = $urandom_range(10, 80);
				end
				run_left--;
				case (style)
					0: m_tready <= 1'b1;
					1: m_tready <= 1'($urandom_range(0, 1));
					default: m_tready <= ($urandom_range(0, 3) == 0);
				endcase
			end
		end
	end

	task automatic send_request(logic [pfsws_pkg::MODE_W-1:0] mode, int key,
			logic [pfsws_pkg::VALUE_W-1:0] value, int wsize);
		int gap;
		int f;
		int j;
		if (mode == pfsws_pkg::MODE_CREATE && wsize >= 1 && wsize <= WIN) begin
			for (f = 0; f < FLOWS; f++)
				if (!flow_taken[f])
					break;
			if (f < FLOWS) begin
				flow_taken[f] = 1'b1;
				live_keys.push_back(f);
			end
		end else if (mode == pfsws_pkg::MODE_REMOVE && flow_taken[key]) begin
			flow_taken[key] = 1'b0;
			for (j = 0; j < live_keys.size(); j++)
				if (live_keys[j] == key) begin
					live_keys.delete(j);
					break;
				end
		end
		if (burst_left == 0) begin
			gap        = ($urandom_range(0, 7) == 0) ? $urandom_range(5, 12) :
				$urandom_range(0, 3);
			burst_left = $urandom_range(1, 24);
			if (gap > 0) begin
				@(negedge clk);
				s_tvalid <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
		end
		burst_left--;
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tuser  <= mode;
		s_tdata  <= {6'b0, wsize[pfsws_pkg::WSIZE_W-1:0], value, key[pfsws_pkg::KEY_W-1:0]};
		do @(posedge clk); while (!s_tready);
		sent++;
	endtask

	function automatic int pick_key();
		if (live_keys.size() > 0 && $urandom_range(0, 9) != 0)
			return live_keys[$urandom_range(0, live_keys.size() - 1)];
		return $urandom_range(0, FLOWS - 1);
	endfunction

	function automatic logic [pfsws_pkg::VALUE_W-1:0] pick_value();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return '1;
			default: return $urandom;
		endcase
	endfunction

	function automatic int bad_size();
		if ($urandom_range(0, 3) == 0)
			return 0;
		return $urandom_range(WIN + 1, (1 << pfsws_pkg::WSIZE_W) - 1);
	endfunction

	function automatic logic [pfsws_pkg::MODE_W-1:0] unknown_mode();
		int m;
		m = $urandom_range(int'(pfsws_pkg::MODE_REMOVE) + 1, (1 << pfsws_pkg::MODE_W) - 1);
		return m[pfsws_pkg::MODE_W-1:0];
	endfunction

	initial begin
		int op;
		int k;
		int key;
		arst_n     = 1'b0;
		s_tvalid   = 1'b0;
		s_tdata    = '0;
		s_tuser    = '0;
		burst_left = 0;
		sent       = 0;
		repeat (9) @(negedge clk);
		arst_n = 1'b1;

		// directed: errors, size limits, wrap of the sum, reuse of a freed flow
		send_request(pfsws_pkg::MODE_GET, 0, '0, 0);
		send_request(pfsws_pkg::MODE_CREATE, 0, '0, 0);
		send_request(pfsws_pkg::MODE_CREATE, 0, '0, WIN + 1);
		send_request(pfsws_pkg::MODE_CREATE, FLOWS - 1, '1, (1 << pfsws_pkg::WSIZE_W) - 1);
		send_request(pfsws_pkg::MODE_CREATE, 0, '0, 1);
		send_request(pfsws_pkg::MODE_CREATE, 0, '0, WIN);
		send_request(pfsws_pkg::MODE_ADD, 0, '1, 0);
		send_request(pfsws_pkg::MODE_ADD, 0, 32'd1, 0);
		send_request(pfsws_pkg::MODE_GET, 0, '0, 0);
		send_request(pfsws_pkg::MODE_ADD, 1, '1, 0);
		send_request(pfsws_pkg::MODE_ADD, 1, '1, 0);
		send_request(pfsws_pkg::MODE_ADD, 1, '0, 0);
		send_request(pfsws_pkg::MODE_GET, 1, '0, 0);
		for (k = int'(pfsws_pkg::MODE_REMOVE) + 1; k < (1 << pfsws_pkg::MODE_W); k++)
			send_request(k[pfsws_pkg::MODE_W-1:0], FLOWS - 1, '1,
				(1 << pfsws_pkg::WSIZE_W) - 1);
		send_request(pfsws_pkg::MODE_ADD, FLOWS - 1, '1, 0);
		send_request(pfsws_pkg::MODE_GET, FLOWS - 1, '0, 0);
		send_request(pfsws_pkg::MODE_REMOVE, FLOWS - 1, '0, 0);
		send_request(pfsws_pkg::MODE_REMOVE, 0, '0, 0);
		send_request(pfsws_pkg::MODE_GET, 0, '0, 0);
		send_request(pfsws_pkg::MODE_REMOVE, 0, '0, 0);
		send_request(pfsws_pkg::MODE_CREATE, 0, '0, 3);
		send_request(pfsws_pkg::MODE_GET, 0, '0, 0);

		// random mix over a small set of flows, mostly add streams each aimed at one flow
		while (sent < 40) begin
			op = $urandom_range(0, 99);
			if (op < 4) begin
				send_request(pfsws_pkg::MODE_CREATE, $urandom_range(0, FLOWS - 1),
					pick_value(), bad_size());
			end else if (op < 16) begin
				if (live_keys.size() < 24)
					send_request(pfsws_pkg::MODE_CREATE, $urandom_range(0, FLOWS - 1),
						pick_value(), $urandom_range(1, WIN));
				else
					send_request(pfsws_pkg::MODE_REMOVE, pick_key(), pick_value(), $urandom);
			end else if (op < 60) begin
				key = pick_key();
				repeat ($urandom_range(1, 20))
					send_request(pfsws_pkg::MODE_ADD, key, pick_value(), $urandom);
				send_request(pfsws_pkg::MODE_GET, key, pick_value(), $urandom);
			end else if (op < 80) begin
				send_request(pfsws_pkg::MODE_GET, pick_key(), pick_value(), $urandom);
			end else if (op < 92) begin
				send_request(live_keys.size() > 4 ? pfsws_pkg::MODE_REMOVE : pfsws_pkg::MODE_GET,
					pick_key(), pick_value(), $urandom);
			end else begin
				send_request(unknown_mode(), $urandom_range(0, FLOWS - 1), pick_value(),
					$urandom);
			end
		end

		// fill the whole table, with some traffic on the flows already there
		while (live_keys.size() < FLOWS) begin
			op = $urandom_range(0, 63);
			if (op == 0)
				send_request(pfsws_pkg::MODE_ADD, pick_key(), pick_value(), $urandom);
			else if (op == 1)
				send_request(pfsws_pkg::MODE_GET, pick_key(), pick_value(), $urandom);
			else
				send_request(pfsws_pkg::MODE_CREATE, $urandom_range(0, FLOWS - 1),
					pick_value(), $urandom_range(1, WIN));
		end

		// table full, then free scattered flows and take them back lowest first
		send_request(pfsws_pkg::MODE_CREATE, 0, '0, 1);
		send_request(pfsws_pkg::MODE_CREATE, FLOWS - 1, '1, WIN);
		send_request(pfsws_pkg::MODE_CREATE, 0, '0, bad_size());
		repeat (8)
			send_request(pfsws_pkg::MODE_REMOVE, pick_key(), pick_value(), $urandom);
		repeat (4)
			send_request(pfsws_pkg::MODE_GET, $urandom_range(0, FLOWS - 1), pick_value(),
				$urandom);
		repeat (9)
			send_request(pfsws_pkg::MODE_CREATE, $urandom_range(0, FLOWS - 1), pick_value(),
				$urandom_range(1, WIN));
		repeat (12)
			send_request(pfsws_pkg::MODE_ADD, FLOWS - 1, pick_value(), $urandom);
		send_request(pfsws_pkg::MODE_GET, FLOWS - 1, '0, 0);

		@(negedge clk);
		s_tvalid <= 1'b0;
		wait (outstanding == 0);
		repeat (40) @(posedge clk);
		if (mismatches == 0 && outstanding == 0)
			$display("per_flow_sliding_window_sum: match");
		else
			$display("per_flow_sliding_window_sum: mismatch");
		$finish;
	end

endmodule

`default_nettype wire

// File: filelist.f
rtl/pfsws_pkg.sv
rtl/per_flow_sliding_window_sum.sv
test/flow_sum_checker.sv
test/per_flow_sliding_window_sum_tb.sv
